### design/thc_pkg.sv
// shared types, register map and constants for the thermal hysteresis controller
package thc_pkg;

    // field widths
    localparam int unsigned TEMP_W      = 12;
    localparam int unsigned HEAT_TH_W   = 11;
    localparam int unsigned PUMP_MODE_W = 2;
    localparam int unsigned ENABLES_W   = 6;
    localparam int unsigned ZONES_MAX   = 4;
    localparam int unsigned ZONE_SRC_W  = 2;
    localparam int unsigned ZONE_TH_W   = ZONES_MAX * TEMP_W;
    localparam int unsigned ZONE_SRCS_W = ZONES_MAX * ZONE_SRC_W;

    // configuration port
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_ADDR_W  = 6;
    localparam int unsigned CFG_IDX_W   = 3;

    // register indexes (byte address is 8 times the index)
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_ON   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_OFF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUMP_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_ON   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_OFF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_SRC  = 3'd6;

    // register reset values
    localparam logic [HEAT_TH_W-1:0]   HEAT_ON_RST   = 11'd10;
    localparam logic [HEAT_TH_W-1:0]   HEAT_OFF_RST  = 11'd100;
    localparam logic [PUMP_MODE_W-1:0] PUMP_MODE_RST = 2'd2;
    localparam logic [ENABLES_W-1:0]   ENABLES_RST   = 6'd0;
    localparam logic [ZONE_TH_W-1:0]   ZONE_ON_RST   = 48'd41241754829400;
    localparam logic [ZONE_TH_W-1:0]   ZONE_OFF_RST  = 48'd34368129024500;
    localparam logic [ZONE_SRCS_W-1:0] ZONE_SRC_RST  = 8'd85;

    // bit positions in pump mode and output enables
    localparam int unsigned PUMP_WITH_HEAT = 0;
    localparam int unsigned PUMP_AT_READY  = 1;
    localparam int unsigned EN_HEATER      = 0;
    localparam int unsigned EN_PUMP        = 1;
    localparam int unsigned EN_ZONE_LSB    = 2;

    // zone temperature sources
    localparam logic [ZONE_SRC_W-1:0] SRC_MOTOR_MAX = 2'd0;
    localparam logic [ZONE_SRC_W-1:0] SRC_BATT_HIGH = 2'd1;

    typedef logic signed [TEMP_W-1:0] t_temp;

    typedef struct packed {
        logic signed [HEAT_TH_W-1:0] heat_on;
        logic signed [HEAT_TH_W-1:0] heat_off;
        logic [PUMP_MODE_W-1:0]      pump_mode;
        logic [ENABLES_W-1:0]        enables;
        logic [ZONE_TH_W-1:0]        zone_on;
        logic [ZONE_TH_W-1:0]        zone_off;
        logic [ZONE_SRCS_W-1:0]      zone_src;
    } t_cfg;

    typedef struct packed {
        logic heater;
        logic pump;
    } t_hp_state;

endpackage

### design/thc_regs.sv
// configuration register file with apb-style access
module thc_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [thc_pkg::CFG_ADDR_W-1:0]    i_paddr,
    input  logic [thc_pkg::CFG_DATA_W-1:0]    i_pwdata,
    output logic [thc_pkg::CFG_DATA_W-1:0]    o_prdata,
    output logic                              o_pready,
    output thc_pkg::t_cfg                     o_cfg
);
    import thc_pkg::*;

    t_cfg                 r_cfg;
    logic [CFG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx    = i_paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heat_on   <= HEAT_ON_RST;
            r_cfg.heat_off  <= HEAT_OFF_RST;
            r_cfg.pump_mode <= PUMP_MODE_RST;
            r_cfg.enables   <= ENABLES_RST;
            r_cfg.zone_on   <= ZONE_ON_RST;
            r_cfg.zone_off  <= ZONE_OFF_RST;
            r_cfg.zone_src  <= ZONE_SRC_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_HEAT_ON:   r_cfg.heat_on   <= i_pwdata[HEAT_TH_W-1:0];
                REG_HEAT_OFF:  r_cfg.heat_off  <= i_pwdata[HEAT_TH_W-1:0];
                REG_PUMP_MODE: r_cfg.pump_mode <= i_pwdata[PUMP_MODE_W-1:0];
                REG_ENABLES:   r_cfg.enables   <= i_pwdata[ENABLES_W-1:0];
                REG_ZONE_ON:   r_cfg.zone_on   <= i_pwdata[ZONE_TH_W-1:0];
                REG_ZONE_OFF:  r_cfg.zone_off  <= i_pwdata[ZONE_TH_W-1:0];
                REG_ZONE_SRC:  r_cfg.zone_src  <= i_pwdata[ZONE_SRCS_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        o_prdata = '0;
        case (w_idx)
            REG_HEAT_ON:   o_prdata[HEAT_TH_W-1:0]   = r_cfg.heat_on;
            REG_HEAT_OFF:  o_prdata[HEAT_TH_W-1:0]   = r_cfg.heat_off;
            REG_PUMP_MODE: o_prdata[PUMP_MODE_W-1:0] = r_cfg.pump_mode;
            REG_ENABLES:   o_prdata[ENABLES_W-1:0]   = r_cfg.enables;
            REG_ZONE_ON:   o_prdata[ZONE_TH_W-1:0]   = r_cfg.zone_on;
            REG_ZONE_OFF:  o_prdata[ZONE_TH_W-1:0]   = r_cfg.zone_off;
            REG_ZONE_SRC:  o_prdata[ZONE_SRCS_W-1:0] = r_cfg.zone_src;
            default:       o_prdata = '0;
        endcase
    end

endmodule

### design/thc_heat_pump.sv
// heater hysteresis and water pump latch, next-state logic for one tick
module thc_heat_pump (
    input  logic                 i_batt_valid,
    input  thc_pkg::t_temp       i_batt_low,
    input  thc_pkg::t_cfg        i_cfg,
    input  thc_pkg::t_hp_state   i_state,
    output thc_pkg::t_hp_state   o_next
);
    import thc_pkg::*;

    logic  w_with_heat;
    logic  w_at_ready;
    logic  w_pump_set;
    logic  w_heat_set;
    logic  w_heat_drop;
    t_temp w_on_th;
    t_temp w_off_th;

    assign w_with_heat = i_cfg.pump_mode[PUMP_WITH_HEAT];
    assign w_at_ready  = i_cfg.pump_mode[PUMP_AT_READY];
    assign w_on_th     = {i_cfg.heat_on[HEAT_TH_W-1], i_cfg.heat_on};
    assign w_off_th    = {i_cfg.heat_off[HEAT_TH_W-1], i_cfg.heat_off};

    // pump latch sees the heater state from before the tick
    assign w_pump_set = i_state.pump | w_at_ready | (i_state.heater & w_with_heat);

    // on sets first, then off clears; off wins when both hold
    assign w_heat_set  = i_state.heater | (i_batt_valid & (i_batt_low < w_on_th));
    assign w_heat_drop = i_batt_valid & w_heat_set & (i_batt_low > w_off_th);

    assign o_next.heater = w_heat_set & ~w_heat_drop;
    assign o_next.pump   = w_pump_set & ~(w_heat_drop & ~w_at_ready);

endmodule

### design/thc_zone.sv
// one cooling zone: source select and hysteresis
module thc_zone (
    input  logic                              i_enable,
    input  logic [thc_pkg::ZONE_SRC_W-1:0]    i_src,
    input  thc_pkg::t_temp                    i_on_th,
    input  thc_pkg::t_temp                    i_off_th,
    input  thc_pkg::t_temp                    i_motor_max,
    input  thc_pkg::t_temp                    i_batt_high,
    input  logic                              i_state,
    output logic                              o_next,
    output logic                              o_cool
);
    import thc_pkg::*;

    t_temp w_temp;
    logic  w_set;
    logic  w_upd;

    // source select, the unused codes read as zero degrees
    always_comb begin
        case (i_src)
            SRC_MOTOR_MAX: w_temp = i_motor_max;
            SRC_BATT_HIGH: w_temp = i_batt_high;
            default:       w_temp = '0;
        endcase
    end

    // on sets, off clears afterwards
    assign w_set = i_state | (w_temp > i_on_th);
    assign w_upd = w_set & ~(w_temp < i_off_th);

    // a zone without output holds its state and reads as off
    assign o_next = i_enable ? w_upd : i_state;
    assign o_cool = i_enable & w_upd;

endmodule

### design/thermal_hysteresis_controller_core.sv
// top level of the thermal hysteresis controller: stream stages, state and config
//
// channel    direction  transaction content
// s stream   in         tuser: battery_temps_valid; tdata: battery temps, motor temps
// m stream   out        tdata: heater, pump and cooling zone outputs
// apb        in/out     seven config registers, 64-bit data at 8-byte steps
//
// one tick per cycle while the result is not stalled; a tick passes the input register, then the result register
// an input register feeds the next-state logic, a result register holds the answer
// state registers update when a tick moves from the input to the result register
// a stalled result keeps the input register filled, the input side then waits
// synchronous active-low reset clears state and both stages, config to defaults
module thermal_hysteresis_controller_core #(
    parameter int unsigned ZONES = thc_pkg::ZONES_MAX
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // in: [11:0] battery_lowest, [23:12] battery_highest, [35:24] inverter_temp,
    // [47:36] controller_system_temp, [59:48] motor_temp, [63:60] zero
    input  logic [63:0]                       i_s_tdata,
    // in: [0] battery_temps_valid
    input  logic                              i_s_tuser,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // out: [0] heater_on, [1] heater_drive, [2] pump_on, [3] pump_drive,
    // [7:4] cooling_on
    output logic [7:0]                        o_m_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [thc_pkg::CFG_ADDR_W-1:0]    i_paddr,
    input  logic [thc_pkg::CFG_DATA_W-1:0]    i_pwdata,
    output logic [thc_pkg::CFG_DATA_W-1:0]    o_prdata,
    output logic                              o_pready
);
    import thc_pkg::*;

    t_cfg                 r_cfg;
    logic                 r_in_valid;
    logic                 r_in_batt_valid;
    t_temp                r_in_low;
    t_temp                r_in_high;
    t_temp                r_in_inv;
    t_temp                r_in_ctrl;
    t_temp                r_in_motor;
    logic                 r_out_valid;
    logic [7:0]           r_out_data;
    t_hp_state            r_hp;
    logic [ZONES-1:0]     r_zone_state;

    t_hp_state            n_hp;
    logic [ZONES-1:0]     n_zone_state;
    logic [7:0]           n_out_data;

    logic                 w_advance;
    logic                 w_in_take;
    t_temp                w_max_ic;
    t_temp                w_motor_max;
    logic [ZONES_MAX-1:0] w_cool;

    // configuration registers
    thc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (r_cfg)
    );

    // handshake between the two stages
    assign w_advance  = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | w_advance;
    assign w_in_take  = i_s_tvalid & o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // hottest of the three motor controller readings
    assign w_max_ic    = (r_in_ctrl > r_in_inv) ? r_in_ctrl : r_in_inv;
    assign w_motor_max = (r_in_motor > w_max_ic) ? r_in_motor : w_max_ic;

    // heater and pump
    thc_heat_pump u_heat_pump (
        .i_batt_valid (r_in_batt_valid),
        .i_batt_low   (r_in_low),
        .i_cfg        (r_cfg),
        .i_state      (r_hp),
        .o_next       (n_hp)
    );

    // cooling zones, missing zones read as off
    for (genvar gi = 0; gi < ZONES_MAX; gi++) begin : g_zone
        if (gi < ZONES) begin : g_used
            thc_zone u_zone (
                .i_enable    (r_cfg.enables[EN_ZONE_LSB+gi]),
                .i_src       (r_cfg.zone_src[gi*ZONE_SRC_W +: ZONE_SRC_W]),
                .i_on_th     (t_temp'(r_cfg.zone_on[gi*TEMP_W +: TEMP_W])),
                .i_off_th    (t_temp'(r_cfg.zone_off[gi*TEMP_W +: TEMP_W])),
                .i_motor_max (w_motor_max),
                .i_batt_high (r_in_high),
                .i_state     (r_zone_state[gi]),
                .o_next      (n_zone_state[gi]),
                .o_cool      (w_cool[gi])
            );
        end else begin : g_absent
            assign w_cool[gi] = 1'b0;
        end
    end

    // result word
    assign n_out_data = {w_cool,
                         n_hp.pump & r_cfg.enables[EN_PUMP],
                         n_hp.pump,
                         n_hp.heater & r_cfg.enables[EN_HEATER],
                         n_hp.heater};

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hp         <= '0;
            r_zone_state <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid  <= 1'b1;
                r_hp         <= n_hp;
                r_zone_state <= n_zone_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_batt_valid <= i_s_tuser;
            r_in_low        <= i_s_tdata[0*TEMP_W +: TEMP_W];
            r_in_high       <= i_s_tdata[1*TEMP_W +: TEMP_W];
            r_in_inv        <= i_s_tdata[2*TEMP_W +: TEMP_W];
            r_in_ctrl       <= i_s_tdata[3*TEMP_W +: TEMP_W];
            r_in_motor      <= i_s_tdata[4*TEMP_W +: TEMP_W];
        end
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

    // assertions
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input side stalled without a blocked result");

    a_drive_needs_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((!o_m_tdata[1] || o_m_tdata[0]) && (!o_m_tdata[3] || o_m_tdata[2])))
        else $error("output drive set without its state");

    a_cool_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[7:4] & ~r_cfg.enables[5:2]) == 4'd0))
        else $error("cooling output on for a zone without output");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && !r_in_valid && !r_hp.heater && !r_hp.pump))
        else $error("reset left a stage or state set");

endmodule

### bench/tb_thermal_hysteresis_controller_core.sv
// self-checking testbench for the thermal hysteresis controller core
module tb_thermal_hysteresis_controller_core;
    import thc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 64;
    localparam int SEG_TICKS   = 45;

    // zone sources that read as a temperature of zero
    localparam logic [ZONE_SRC_W-1:0] SRC_ZERO_A = 2'd2;
    localparam logic [ZONE_SRC_W-1:0] SRC_ZERO_B = 2'd3;

    // one tick as carried on the input stream
    typedef struct {
        logic  valid;
        t_temp lo;
        t_temp hi;
        t_temp inv;
        t_temp ctl;
        t_temp mot;
    } t_tick;

    // predicts heater, pump and zone outputs and checks them in order
    class thc_scoreboard;
        int                     heat_on;
        int                     heat_off;
        logic [PUMP_MODE_W-1:0] pump_mode;
        logic [ENABLES_W-1:0]   enables;
        logic [ZONE_TH_W-1:0]   zone_on;
        logic [ZONE_TH_W-1:0]   zone_off;
        logic [ZONE_SRCS_W-1:0] zone_src;
        logic                   heater;
        logic                   pump;
        logic [ZONES_MAX-1:0]   zone_cool;
        logic [7:0]             outputs_due[$];
        int                     errors;
        int                     checked;
        int                     ticks;

        function new();
            heat_on   = 10;
            heat_off  = 100;
            pump_mode = PUMP_MODE_RST;
            enables   = ENABLES_RST;
            zone_on   = ZONE_ON_RST;
            zone_off  = ZONE_OFF_RST;
            zone_src  = ZONE_SRC_RST;
            heater    = 1'b0;
            pump      = 1'b0;
            zone_cool = '0;
            errors    = 0;
            checked   = 0;
            ticks     = 0;
        endfunction

        // mirror of a register write
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            logic signed [HEAT_TH_W-1:0] th;
            th = val[HEAT_TH_W-1:0];
            case (idx)
                REG_HEAT_ON:   heat_on = int'(th);
                REG_HEAT_OFF:  heat_off = int'(th);
                REG_PUMP_MODE: pump_mode = val[PUMP_MODE_W-1:0];
                REG_ENABLES:   enables = val[ENABLES_W-1:0];
                REG_ZONE_ON:   zone_on = val[ZONE_TH_W-1:0];
                REG_ZONE_OFF:  zone_off = val[ZONE_TH_W-1:0];
                REG_ZONE_SRC:  zone_src = val[ZONE_SRCS_W-1:0];
                default: ;
            endcase
        endfunction

        // advance the state by one accepted tick and queue the expected outputs
        function void predict_tick(t_tick tk);
            int               lo;
            int               hi;
            int               mmax;
            int               temp;
            int               on_t;
            int               off_t;
            t_temp            th;
            logic             with_heat;
            logic             at_ready;
            logic [1:0]       src;
            logic [7:0]       res;
            lo        = int'(tk.lo);
            hi        = int'(tk.hi);
            mmax      = int'(tk.inv);
            with_heat = pump_mode[PUMP_WITH_HEAT];
            at_ready  = pump_mode[PUMP_AT_READY];
            res       = '0;
            ticks++;
            if (int'(tk.ctl) > mmax) mmax = int'(tk.ctl);
            if (int'(tk.mot) > mmax) mmax = int'(tk.mot);

            // pump latch sees the heater from before this tick
            if (!pump && (at_ready || (heater && with_heat)))
                pump = 1'b1;

            // heater hysteresis, off wins and takes the pump along
            if (tk.valid) begin
                if (lo < heat_on)
                    heater = 1'b1;
                if (lo > heat_off && heater) begin
                    heater = 1'b0;
                    if (pump && !at_ready)
                        pump = 1'b0;
                end
            end

            // cooling zones, absent outputs keep their state
            for (int z = 0; z < ZONES_MAX; z++) begin
                if (!enables[EN_ZONE_LSB + z])
                    continue;
                th    = zone_on[TEMP_W*z +: TEMP_W];
                on_t  = int'(th);
                th    = zone_off[TEMP_W*z +: TEMP_W];
                off_t = int'(th);
                src   = zone_src[ZONE_SRC_W*z +: ZONE_SRC_W];
                if (src == SRC_MOTOR_MAX)
                    temp = mmax;
                else if (src == SRC_BATT_HIGH)
                    temp = hi;
                else
                    temp = 0;
                if (temp > on_t)
                    zone_cool[z] = 1'b1;
                if (temp < off_t)
                    zone_cool[z] = 1'b0;
                res[4 + z] = zone_cool[z];
            end

            res[0] = heater;
            res[1] = heater & enables[EN_HEATER];
            res[2] = pump;
            res[3] = pump & enables[EN_PUMP];
            outputs_due = {outputs_due, res};
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("mismatch at output %0d: %s", checked, msg);
            errors++;
        endtask

        // compare one output transaction with the oldest prediction
        task check_outputs(logic [7:0] got);
            logic [7:0] want;
            if (outputs_due.size() == 0) begin
                report($sformatf("output %h with no tick pending", got));
                return;
            end
            want = outputs_due.pop_front();
            if (got[0] !== want[0])
                report($sformatf("heater_on got %b want %b", got[0], want[0]));
            if (got[1] !== want[1])
                report($sformatf("heater_drive got %b want %b", got[1], want[1]));
            if (got[2] !== want[2])
                report($sformatf("pump_on got %b want %b", got[2], want[2]));
            if (got[3] !== want[3])
                report($sformatf("pump_drive got %b want %b", got[3], want[3]));
            if (got[7:4] !== want[7:4])
                report($sformatf("cooling_on got %b want %b", got[7:4], want[7:4]));
            checked++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic [63:0]           i_s_tdata;
    logic                  i_s_tuser;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [7:0]            o_m_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic                  i_psel;
    logic                  i_penable;
    logic                  i_pwrite;
    logic [CFG_ADDR_W-1:0] i_paddr;
    logic [CFG_DATA_W-1:0] i_pwdata;
    logic [CFG_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    thc_scoreboard sb;
    int            src_idle_pct;
    int            snk_stall_pct;
    int            cycle_count;
    int            settings;
    logic          hold_go;
    logic          hold_done;
    int            hold_left;

    thermal_hysteresis_controller_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output side: check accepted transactions, random stalls, one long hold-off
    initial begin
        hold_done = 1'b0;
        hold_left = 0;
    end
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready)
            sb.check_outputs(o_m_tdata);
        if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // temperature mostly around the thresholds, sometimes anywhere in range
    function automatic t_temp rand_temp();
        t_temp t;
        if ($urandom_range(99) < 75)
            t = t_temp'(int'($urandom_range(1500)) - 300);
        else
            t = t_temp'($urandom_range(4095));
        return t;
    endfunction

    function automatic logic [ZONE_TH_W-1:0] pack_zones(int z0, int z1, int z2, int z3);
        t_temp a, b, c, d;
        a = t_temp'(z0);
        b = t_temp'(z1);
        c = t_temp'(z2);
        d = t_temp'(z3);
        return {d, c, b, a};
    endfunction

    // one register write: setup cycle then access cycle
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 3'b000};
        i_pwdata  <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (o_pready !== 1'b1) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one tick, with a random gap before it
    task automatic send_tick(t_tick tk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= tk.valid;
        i_s_tdata  <= {4'b0000, tk.mot, tk.ctl, tk.inv, tk.hi, tk.lo};
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        sb.predict_tick(tk);
    endtask

    task automatic tick(logic v, int lo, int hi, int inv, int ctl, int mot);
        t_tick tk;
        tk.valid = v;
        tk.lo    = t_temp'(lo);
        tk.hi    = t_temp'(hi);
        tk.inv   = t_temp'(inv);
        tk.ctl   = t_temp'(ctl);
        tk.mot   = t_temp'(mot);
        send_tick(tk);
    endtask

    // stop offering and wait until every predicted output has arrived
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outputs_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        settings++;
    endtask

    // a random register setting, thresholds mostly in hysteresis order
    task automatic cfg_random();
        int                   a;
        int                   b;
        int                   base;
        int                   gap;
        t_temp                t;
        logic [ZONE_TH_W-1:0] zon;
        logic [ZONE_TH_W-1:0] zoff;
        a = int'($urandom_range(1100)) - 100;
        b = int'($urandom_range(1100)) - 100;
        if ($urandom_range(99) < 80 && a > b) begin
            base = a;
            a    = b;
            b    = base;
        end
        for (int z = 0; z < ZONES_MAX; z++) begin
            base = int'($urandom_range(1400)) - 200;
            gap  = int'($urandom_range(300));
            if ($urandom_range(99) < 20)
                gap = -gap;
            if ($urandom_range(99) < 10) begin
                t = t_temp'($urandom_range(4095));
                zon[TEMP_W*z +: TEMP_W] = t;
                t = t_temp'($urandom_range(4095));
                zoff[TEMP_W*z +: TEMP_W] = t;
            end else begin
                t = t_temp'(base + gap);
                zon[TEMP_W*z +: TEMP_W] = t;
                t = t_temp'(base);
                zoff[TEMP_W*z +: TEMP_W] = t;
            end
        end
        cfg_write(REG_HEAT_ON, CFG_DATA_W'(a));
        cfg_write(REG_HEAT_OFF, CFG_DATA_W'(b));
        cfg_write(REG_PUMP_MODE, CFG_DATA_W'($urandom_range(3)));
        cfg_write(REG_ENABLES,
                  CFG_DATA_W'(($urandom_range(99) < 50) ? 63 : $urandom_range(63)));
        cfg_write(REG_ZONE_ON, CFG_DATA_W'(zon));
        cfg_write(REG_ZONE_OFF, CFG_DATA_W'(zoff));
        cfg_write(REG_ZONE_SRC, CFG_DATA_W'($urandom_range(255)));
    endtask

    // stimulus
    initial begin
        t_tick tk;
        sb            = new();
        src_idle_pct  = 18;
        snk_stall_pct = 56;
        settings      = 0;
        i_rst_n    <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_m_tready <= 1'b0;
        i_psel     <= 1'b0;
        i_penable  <= 1'b0;
        i_pwrite   <= 1'b0;
        i_paddr    <= '0;
        i_pwdata   <= '0;
        hold_go    <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // heater hysteresis, pump with heat, each zone source
        cfg_write(REG_HEAT_ON, CFG_DATA_W'(200));
        cfg_write(REG_HEAT_OFF, CFG_DATA_W'(400));
        cfg_write(REG_PUMP_MODE, CFG_DATA_W'(1));
        cfg_write(REG_ENABLES, CFG_DATA_W'(63));
        cfg_write(REG_ZONE_ON, CFG_DATA_W'(pack_zones(300, 500, -10, -10)));
        cfg_write(REG_ZONE_OFF, CFG_DATA_W'(pack_zones(100, 450, -50, 10)));
        cfg_write(REG_ZONE_SRC,
                  CFG_DATA_W'({SRC_ZERO_B, SRC_ZERO_A, SRC_BATT_HIGH, SRC_MOTOR_MAX}));
        tick(1'b1, 100, 0, 350, -2048, 2047);
        tick(1'b1, 300, 0, -2048, 250, -2048);
        tick(1'b0, 2047, 0, 0, 0, 0);
        tick(1'b1, 2047, 2047, 0, 0, 0);
        tick(1'b1, -2048, -2048, -2048, -2048, -2048);
        tick(1'b1, 300, 460, 0, 301, 0);
        tick(1'b1, 300, 0, 0, 0, 301);
        drain();

        // both heater thresholds hold, zones absent and held
        cfg_write(REG_HEAT_ON, CFG_DATA_W'(500));
        cfg_write(REG_HEAT_OFF, CFG_DATA_W'(100));
        cfg_write(REG_ENABLES, CFG_DATA_W'(3));
        tick(1'b1, 300, 2047, 2047, 0, 0);
        tick(1'b1, 300, -2048, -2048, 0, 0);
        tick(1'b0, 300, 0, 0, 0, 0);
        drain();

        // run at ready keeps the pump through a heater drop
        cfg_write(REG_PUMP_MODE, CFG_DATA_W'(3));
        tick(1'b1, 300, 0, 0, 0, 0);
        tick(1'b1, 2047, 0, 0, 0, 0);
        drain();

        // no pump mode, zones come back with their held state
        cfg_write(REG_PUMP_MODE, CFG_DATA_W'(0));
        cfg_write(REG_ENABLES, CFG_DATA_W'(63));
        tick(1'b1, 50, 0, 0, 0, 0);
        tick(1'b1, 2047, 0, 0, 0, 0);
        drain();
        cfg_write(REG_PUMP_MODE, CFG_DATA_W'(2));
        tick(1'b1, 300, 0, 0, 0, 0);
        drain();

        // register extremes
        cfg_write(REG_HEAT_ON, CFG_DATA_W'(-100));
        cfg_write(REG_HEAT_OFF, CFG_DATA_W'(1000));
        cfg_write(REG_ZONE_ON, CFG_DATA_W'(pack_zones(2047, -2048, 0, -1)));
        cfg_write(REG_ZONE_OFF, CFG_DATA_W'(pack_zones(-2048, 2047, 0, -1)));
        cfg_write(REG_ZONE_SRC,
                  CFG_DATA_W'({SRC_MOTOR_MAX, SRC_BATT_HIGH, SRC_ZERO_A, SRC_BATT_HIGH}));
        tick(1'b1, -101, 2047, 2047, 2047, 2047);
        tick(1'b1, 1001, -2048, -2048, -2048, -2048);
        tick(1'b1, -100, -1, -1, 0, 0);
        tick(1'b1, 1000, 0, 0, -1, 1);
        drain();

        // random ticks over three idle profiles, several settings in each
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 18 : (ph == 1) ? 56 : 0;
            snk_stall_pct = (ph == 0) ? 56 : (ph == 1) ? 18 : 0;
            for (int seg = 0; seg < 3; seg++) begin
                cfg_random();
                for (int n = 0; n < SEG_TICKS; n++) begin
                    if (ph == 2 && seg == 1 && n == 5)
                        hold_go <= 1'b1;
                    tk.valid = ($urandom_range(99) < 85);
                    tk.lo    = rand_temp();
                    tk.hi    = rand_temp();
                    tk.inv   = rand_temp();
                    tk.ctl   = rand_temp();
                    tk.mot   = rand_temp();
                    send_tick(tk);
                end
                drain();
            end
        end

        repeat (8) @(posedge i_clk);
        $display("covered %0d ticks under %0d register settings, three idle profiles",
                 sb.ticks, settings);
        $display("%0d output transactions checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.outputs_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
